@@ rtl/qeti_pkg.sv @@
// ----------------------------------------------------------------------------
// qeti_pkg
// Shared widths, types, codes and the control store of the quintic
// escape-time iterator.
// ----------------------------------------------------------------------------
package qeti_pkg;

  // number formats
  localparam int FRAC_BITS = 28;
  localparam int INT_BITS  = 12;
  localparam int PORT_W    = 32;
  localparam int PORT_FRAC = 28;
  localparam int VAL_W     = INT_BITS + FRAC_BITS + 1;
  localparam int MAG_W     = VAL_W - 1;
  localparam int HALF_W    = (MAG_W + 1) / 2;
  localparam int ACC_W     = 4 * HALF_W;

  // port to internal scaling
  localparam int UP_SH = (FRAC_BITS >= PORT_FRAC) ? (FRAC_BITS - PORT_FRAC) : 0;
  localparam int DN_SH = (FRAC_BITS <  PORT_FRAC) ? (PORT_FRAC - FRAC_BITS) : 0;

  // other widths
  localparam int CNT_W     = 9;
  localparam int MAXIT_W   = 8;
  localparam int ESC_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int PC_W      = 5;
  localparam int RF_AW     = 4;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t MAXV = {1'b0, {MAG_W{1'b1}}};

  // register reset values
  localparam logic [PORT_W-1:0]  COEF_RE_RST   = 32'h1000_0000;
  localparam logic [PORT_W-1:0]  COEF_IM_RST   = 32'h0000_0000;
  localparam logic [MAXIT_W-1:0] MAX_ITER_RST  = 8'd255;
  localparam logic [ESC_W-1:0]   ESC_LIMIT_RST = 5'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_RE   = 2'd0,
    CFG_COEF_IM   = 2'd1,
    CFG_MAX_ITER  = 2'd2,
    CFG_ESC_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_CLR = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_TST = 3'd4,
    OP_JMP = 3'd5
  } op_e;

  // operands: codes below OPD_AR are register file addresses
  typedef enum logic [3:0] {
    OPD_ZR  = 4'd0,
    OPD_ZI  = 4'd1,
    OPD_Z2R = 4'd2,
    OPD_Z2I = 4'd3,
    OPD_Z4R = 4'd4,
    OPD_Z4I = 4'd5,
    OPD_T0  = 4'd6,
    OPD_T1  = 4'd7,
    OPD_T2  = 4'd8,
    OPD_AR  = 4'd9,
    OPD_AI  = 4'd10,
    OPD_CR  = 4'd11,
    OPD_CI  = 4'd12
  } opnd_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EXEC = 2'd2,
    S_MULW = 2'd3
  } seq_state_e;

  typedef struct packed {
    op_e              op;
    opnd_e            src_a;
    opnd_e            src_b;
    opnd_e            dst;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic we;
    logic mul_start;
  } dp_ctrl_t;

  typedef struct packed {
    logic mul_done;
    logic below_limit;
  } dp_stat_t;

  localparam logic [PC_W-1:0] PC_LOOP = PC_W'(2);
  localparam logic [PC_W-1:0] PC_NONE = PC_W'(0);

  // control store: clear z, then one iteration of z := z^5 + a*z + c with the escape check
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      // clear z
      5'd0:  w = '{OP_CLR, OPD_ZR,  OPD_ZR,  OPD_ZR,  PC_NONE};
      5'd1:  w = '{OP_CLR, OPD_ZI,  OPD_ZI,  OPD_ZI,  PC_NONE};
      // squared magnitude and exit check
      5'd2:  w = '{OP_MUL, OPD_ZR,  OPD_ZR,  OPD_T0,  PC_NONE};
      5'd3:  w = '{OP_MUL, OPD_ZI,  OPD_ZI,  OPD_T1,  PC_NONE};
      5'd4:  w = '{OP_ADD, OPD_T0,  OPD_T1,  OPD_T2,  PC_NONE};
      5'd5:  w = '{OP_TST, OPD_T2,  OPD_T2,  OPD_T2,  PC_NONE};
      // z2 = z * z, reusing the squares
      5'd6:  w = '{OP_SUB, OPD_T0,  OPD_T1,  OPD_Z2R, PC_NONE};
      5'd7:  w = '{OP_MUL, OPD_ZR,  OPD_ZI,  OPD_T0,  PC_NONE};
      5'd8:  w = '{OP_ADD, OPD_T0,  OPD_T0,  OPD_Z2I, PC_NONE};
      // z4 = z2 * z2
      5'd9:  w = '{OP_MUL, OPD_Z2R, OPD_Z2R, OPD_T0,  PC_NONE};
      5'd10: w = '{OP_MUL, OPD_Z2I, OPD_Z2I, OPD_T1,  PC_NONE};
      5'd11: w = '{OP_SUB, OPD_T0,  OPD_T1,  OPD_Z4R, PC_NONE};
      5'd12: w = '{OP_MUL, OPD_Z2R, OPD_Z2I, OPD_T0,  PC_NONE};
      5'd13: w = '{OP_ADD, OPD_T0,  OPD_T0,  OPD_Z4I, PC_NONE};
      // z5 = z4 * z, kept in the z2 slots
      5'd14: w = '{OP_MUL, OPD_Z4R, OPD_ZR,  OPD_T0,  PC_NONE};
      5'd15: w = '{OP_MUL, OPD_Z4I, OPD_ZI,  OPD_T1,  PC_NONE};
      5'd16: w = '{OP_SUB, OPD_T0,  OPD_T1,  OPD_Z2R, PC_NONE};
      5'd17: w = '{OP_MUL, OPD_Z4R, OPD_ZI,  OPD_T0,  PC_NONE};
      5'd18: w = '{OP_MUL, OPD_Z4I, OPD_ZR,  OPD_T1,  PC_NONE};
      5'd19: w = '{OP_ADD, OPD_T0,  OPD_T1,  OPD_Z2I, PC_NONE};
      // a * z, kept in the z4 slots
      5'd20: w = '{OP_MUL, OPD_AR,  OPD_ZR,  OPD_T0,  PC_NONE};
      5'd21: w = '{OP_MUL, OPD_AI,  OPD_ZI,  OPD_T1,  PC_NONE};
      5'd22: w = '{OP_SUB, OPD_T0,  OPD_T1,  OPD_Z4R, PC_NONE};
      5'd23: w = '{OP_MUL, OPD_AR,  OPD_ZI,  OPD_T0,  PC_NONE};
      5'd24: w = '{OP_MUL, OPD_AI,  OPD_ZR,  OPD_T1,  PC_NONE};
      5'd25: w = '{OP_ADD, OPD_T0,  OPD_T1,  OPD_Z4I, PC_NONE};
      // new z
      5'd26: w = '{OP_ADD, OPD_Z2R, OPD_Z4R, OPD_T0,  PC_NONE};
      5'd27: w = '{OP_ADD, OPD_T0,  OPD_CR,  OPD_ZR,  PC_NONE};
      5'd28: w = '{OP_ADD, OPD_Z2I, OPD_Z4I, OPD_T0,  PC_NONE};
      5'd29: w = '{OP_ADD, OPD_T0,  OPD_CI,  OPD_ZI,  PC_NONE};
      // count and loop
      5'd30: w = '{OP_JMP, OPD_T0,  OPD_T0,  OPD_T0,  PC_LOOP};
      default: w = '{OP_JMP, OPD_T0, OPD_T0, OPD_T0,  PC_LOOP};
    endcase
    return w;
  endfunction

  // port format to internal format; a port value always fits the range
  function automatic val_t from_port(input logic signed [PORT_W-1:0] v);
    val_t x;
    x = VAL_W'(v);
    x = x <<< UP_SH;
    x = x >>> DN_SH;
    return x;
  endfunction

  // clamp a sum to the symmetric range
  function automatic val_t sat_sum(input logic signed [VAL_W:0] s);
    logic signed [VAL_W:0] hi;
    logic signed [VAL_W:0] lo;
    val_t r;
    hi = {2'b00, {MAG_W{1'b1}}};
    lo = -hi;
    if (s > hi) begin
      r = MAXV;
    end else if (s < lo) begin
      r = -MAXV;
    end else begin
      r = s[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/qeti_regfile.sv @@
// ----------------------------------------------------------------------------
// qeti_regfile
// Scratch register file: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module qeti_regfile #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem_q [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/qeti_mul.sv @@
// ----------------------------------------------------------------------------
// qeti_mul
// Multi-cycle saturating fixed-point multiplier built from four half-width
// partial products on a single multiplier.
// ----------------------------------------------------------------------------
module qeti_mul import qeti_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  val_t a_i,
  input  val_t b_i,
  output logic done_o,
  output val_t res_o
);

  logic [MAG_W-1:0]      mag_a;
  logic [MAG_W-1:0]      mag_b;
  val_t                  neg_a;
  val_t                  neg_b;
  logic [2*HALF_W-1:0]   xa_q;
  logic [2*HALF_W-1:0]   xb_q;
  logic                  neg_q;
  logic                  busy_q;
  logic                  done_q;
  logic [2:0]            cnt_q;
  logic [HALF_W-1:0]     half_a;
  logic [HALF_W-1:0]     half_b;
  logic [2*HALF_W-1:0]   pp_q;
  logic [1:0]            acc_idx;
  logic [ACC_W-1:0]      term;
  logic [ACC_W-1:0]      acc_q;
  logic [ACC_W-FRAC_BITS-1:0] quo;
  logic                  ovf;
  val_t                  mag_r;

  // operand magnitudes
  assign neg_a = -a_i;
  assign neg_b = -b_i;
  assign mag_a = a_i[VAL_W-1] ? neg_a[MAG_W-1:0] : a_i[MAG_W-1:0];
  assign mag_b = b_i[VAL_W-1] ? neg_b[MAG_W-1:0] : b_i[MAG_W-1:0];

  // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  assign half_a = cnt_q[1] ? xa_q[2*HALF_W-1:HALF_W] : xa_q[HALF_W-1:0];
  assign half_b = cnt_q[0] ? xb_q[2*HALF_W-1:HALF_W] : xb_q[HALF_W-1:0];

  // alignment of the partial product being accumulated
  assign acc_idx = cnt_q[1:0] - 2'd1;
  always_comb begin
    case (acc_idx)
      2'd0:    term = ACC_W'(pp_q);
      2'd3:    term = ACC_W'(pp_q) << (2 * HALF_W);
      default: term = ACC_W'(pp_q) << HALF_W;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd4) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // operands, partial product and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xa_q  <= (2*HALF_W)'(mag_a);
      xb_q  <= (2*HALF_W)'(mag_b);
      neg_q <= a_i[VAL_W-1] ^ b_i[VAL_W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q <= half_a * half_b;
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + term;
      end
    end
  end

  // truncate the fraction, clamp and apply the sign
  assign quo   = acc_q[ACC_W-1:FRAC_BITS];
  assign ovf   = |quo[ACC_W-FRAC_BITS-1:MAG_W];
  assign mag_r = ovf ? MAXV : {1'b0, quo[MAG_W-1:0]};
  assign res_o = neg_q ? -mag_r : mag_r;
  assign done_o = done_q;

endmodule

@@ rtl/qeti_datapath.sv @@
// ----------------------------------------------------------------------------
// qeti_datapath
// Operand registers, scratch register file, saturating adder and the shared
// multiplier, steered by the current control word.
// ----------------------------------------------------------------------------
module qeti_datapath import qeti_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_ctrl_t           ctrl_i,
  input  ucode_t             word_i,
  input  logic [PORT_W-1:0]  point_re_i,
  input  logic [PORT_W-1:0]  point_im_i,
  input  logic [PORT_W-1:0]  coef_re_i,
  input  logic [PORT_W-1:0]  coef_im_i,
  input  logic [ESC_W-1:0]   esc_limit_i,
  output dp_stat_t           stat_o
);

  val_t ar_q;
  val_t ai_q;
  val_t cr_q;
  val_t ci_q;
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;
  val_t opa;
  val_t opb;
  val_t add_res;
  val_t sub_res;
  val_t mul_res;
  val_t wdata;
  val_t limit;
  logic mul_done;

  // point and coefficient captured at input transfer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cr_q <= from_port(point_re_i);
      ci_q <= from_port(point_im_i);
      ar_q <= from_port(coef_re_i);
      ai_q <= from_port(coef_im_i);
    end
  end

  // scratch registers
  qeti_regfile #(
    .DW (VAL_W),
    .AW (RF_AW)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (ctrl_i.we),
    .waddr_i   (RF_AW'(word_i.dst)),
    .wdata_i   (wdata),
    .raddr_a_i (RF_AW'(word_i.src_a)),
    .raddr_b_i (RF_AW'(word_i.src_b)),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // operand select
  always_comb begin
    case (word_i.src_a)
      OPD_AR:  opa = ar_q;
      OPD_AI:  opa = ai_q;
      OPD_CR:  opa = cr_q;
      OPD_CI:  opa = ci_q;
      default: opa = rd_a;
    endcase
  end

  always_comb begin
    case (word_i.src_b)
      OPD_AR:  opb = ar_q;
      OPD_AI:  opb = ai_q;
      OPD_CR:  opb = cr_q;
      OPD_CI:  opb = ci_q;
      default: opb = rd_b;
    endcase
  end

  // saturating add and subtract
  assign add_res = sat_sum((VAL_W+1)'(opa) + (VAL_W+1)'(opb));
  assign sub_res = sat_sum((VAL_W+1)'(opa) - (VAL_W+1)'(opb));

  // shared multiplier
  qeti_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // write-back select
  always_comb begin
    case (word_i.op)
      OP_ADD:  wdata = add_res;
      OP_SUB:  wdata = sub_res;
      OP_MUL:  wdata = mul_res;
      default: wdata = '0;
    endcase
  end

  // escape bound in internal format
  assign limit = val_t'(VAL_W'(esc_limit_i) << FRAC_BITS);

  assign stat_o.mul_done    = mul_done;
  assign stat_o.below_limit = (opa < limit);

endmodule

@@ rtl/qeti_seq.sv @@
// ----------------------------------------------------------------------------
// qeti_seq
// Microcode sequencer: step counter, iteration counter, handshakes and the
// result register.
// ----------------------------------------------------------------------------
module qeti_seq import qeti_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CNT_W-1:0]   iter_count_o,
  output logic               escaped_o,
  input  logic [MAXIT_W-1:0] max_iter_i,
  input  dp_stat_t           stat_i,
  output ucode_t             word_o,
  output dp_ctrl_t           ctrl_o
);

  seq_state_e         state_q, state_d;
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [CNT_W-1:0]   count_q, count_d;
  ucode_t             word;
  logic               leave;
  logic               out_free;
  logic               out_load;
  logic               out_valid_q;
  logic [CNT_W-1:0]   iter_count_q;
  logic               escaped_q;

  assign word     = ucode_rom(pc_q);
  assign leave    = !stat_i.below_limit || (count_q > CNT_W'(max_iter_i));
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    count_d = count_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_READ;
          pc_d    = '0;
          count_d = '0;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        case (word.op)
          OP_MUL: begin
            state_d = S_MULW;
          end
          OP_TST: begin
            if (leave) begin
              if (out_free) begin
                state_d = S_IDLE;
              end
            end else begin
              pc_d    = pc_q + 1'b1;
              state_d = S_READ;
            end
          end
          OP_JMP: begin
            pc_d    = word.target;
            count_d = count_q + 1'b1;
            state_d = S_READ;
          end
          default: begin
            pc_d    = pc_q + 1'b1;
            state_d = S_READ;
          end
        endcase
      end
      S_MULW: begin
        if (stat_i.mul_done) begin
          pc_d    = pc_q + 1'b1;
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o       = (state_q == S_IDLE);
    ctrl_o.load      = (state_q == S_IDLE) && in_valid_i;
    ctrl_o.mul_start = (state_q == S_EXEC) && (word.op == OP_MUL);
    ctrl_o.we        = ((state_q == S_EXEC) &&
                        ((word.op == OP_CLR) || (word.op == OP_ADD) ||
                         (word.op == OP_SUB))) ||
                       ((state_q == S_MULW) && stat_i.mul_done);
    out_load         = (state_q == S_EXEC) && (word.op == OP_TST) && leave && out_free;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      iter_count_q <= count_q;
      escaped_q    <= (count_q < CNT_W'(max_iter_i));
    end
  end

  assign word_o       = word;
  assign out_valid_o  = out_valid_q;
  assign iter_count_o = iter_count_q;
  assign escaped_o    = escaped_q;

endmodule

@@ rtl/quintic_escape_time_iterator_unit.sv @@
// Each iteration runs 14 multiplies on the one shared multiplier and 15 other
// steps; the reported iteration count ranges from 0 to 256.
// One point is handled at a time; the next is taken once the result is loaded.
// Reset: sequencer idle, result invalid, configuration registers at their
// defaults; the scratch registers are not cleared.
// ----------------------------------------------------------------------------
// quintic_escape_time_iterator_unit
// Escape-time iteration of z := z^5 + a*z + c in saturating fixed point,
// run by a microcoded sequencer over a shared datapath.
// ----------------------------------------------------------------------------
module quintic_escape_time_iterator_unit import qeti_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PORT_W-1:0]    cfg_wdata_i,
  // input point
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [PORT_W-1:0] point_re_i,
  input  logic signed [PORT_W-1:0] point_im_i,
  // result
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CNT_W-1:0]     iter_count_o,
  output logic                 escaped_o
);

  logic [PORT_W-1:0]  coef_re_q;
  logic [PORT_W-1:0]  coef_im_q;
  logic [MAXIT_W-1:0] max_iter_q;
  logic [ESC_W-1:0]   esc_limit_q;
  ucode_t             word;
  dp_ctrl_t           ctrl;
  dp_stat_t           stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_re_q   <= COEF_RE_RST;
      coef_im_q   <= COEF_IM_RST;
      max_iter_q  <= MAX_ITER_RST;
      esc_limit_q <= ESC_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_RE:   coef_re_q   <= cfg_wdata_i;
        CFG_COEF_IM:   coef_im_q   <= cfg_wdata_i;
        CFG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[MAXIT_W-1:0];
        CFG_ESC_LIMIT: esc_limit_q <= cfg_wdata_i[ESC_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  qeti_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .iter_count_o (iter_count_o),
    .escaped_o    (escaped_o),
    .max_iter_i   (max_iter_q),
    .stat_i       (stat),
    .word_o       (word),
    .ctrl_o       (ctrl)
  );

  // datapath
  qeti_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .word_i      (word),
    .point_re_i  (point_re_i),
    .point_im_i  (point_im_i),
    .coef_re_i   (coef_re_q),
    .coef_im_i   (coef_im_q),
    .esc_limit_i (esc_limit_q),
    .stat_o      (stat)
  );

endmodule
